// ===== rtl/core/rlp_typed_transaction_serializer_top_defines.svh =====
// Assertion macros for the typed transaction serializer.
// Included by the top level; expects aclk and aresetn in scope.
`ifndef RLP_TYPED_TRANSACTION_SERIALIZER_TOP_DEFINES_SVH
`define RLP_TYPED_TRANSACTION_SERIALIZER_TOP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define RLP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define RLP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rlp_pkg.sv =====
// Shared types, codes and constants of the typed transaction serializer.
// No dependencies; imported by every module of the block.
package rlp_pkg;

    localparam int MAX_CALLDATA_DEF = 256;

    // Command codes (carried in tuser)
    localparam logic [1:0] CMD_LOAD_INT  = 2'd0;
    localparam logic [1:0] CMD_LOAD_BYTE = 2'd1;
    localparam logic [1:0] CMD_BEGIN     = 2'd2;
    localparam logic [1:0] CMD_READ      = 2'd3;

    // Byte targets
    localparam logic [1:0] TGT_ADDR = 2'd0;
    localparam logic [1:0] TGT_DATA = 2'd1;

    // Integer field holding the calldata length
    localparam logic [2:0] FIELD_CD_LEN = 3'd7;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LIMIT    = 2'd1;
    localparam logic [1:0] ST_CALLDATA = 2'd2;

    // Report kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // Register indexes
    localparam logic REG_INCLUDE_SIG  = 1'b0;
    localparam logic REG_OUTPUT_LIMIT = 1'b1;

    // RLP prefixes
    localparam logic [7:0] STR_SHORT  = 8'h80;
    localparam logic [7:0] STR_LONG   = 8'hB7;
    localparam logic [7:0] LIST_SHORT = 8'hC0;
    localparam logic [7:0] LIST_LONG  = 8'hF7;
    localparam logic [7:0] TX_TYPE    = 8'h02;
    localparam int         SHORT_MAX  = 55;
    localparam int         ADDR_LEN   = 20;

    // Byte store map: address at 0, r at 32, s at 64, calldata at 256
    localparam int         STORE_DEPTH = 512;
    localparam int         STORE_AW    = $clog2(STORE_DEPTH);
    localparam logic [8:0] SRC_SIG_BASE = 9'd32;
    localparam logic [8:0] SRC_CD_BASE  = 9'd256;
    // Items start here in the output store; prefix and list header sit below
    localparam logic [8:0] HDR_ROOM = 9'd4;

    // List items in encoding order
    localparam logic [3:0] ITEM_GAS   = 4'd4;
    localparam logic [3:0] ITEM_ADDR  = 4'd5;
    localparam logic [3:0] ITEM_VALUE = 4'd6;
    localparam logic [3:0] ITEM_DATA  = 4'd7;
    localparam logic [3:0] ITEM_ACL   = 4'd8;
    localparam logic [3:0] ITEM_V     = 4'd9;
    localparam logic [3:0] ITEM_R     = 4'd10;
    localparam logic [3:0] ITEM_S     = 4'd11;

    typedef logic [6:0][63:0] int_fields_t;

    typedef enum logic [1:0] {T_IDLE, T_ENC, T_RD} top_state_t;
    typedef enum logic [2:0] {E_IDLE, E_SCAN, E_ITEM, E_HDR, E_DONE} enc_state_t;

    typedef struct packed {
        logic       done;
        logic [1:0] status;
        logic [9:0] length;
        logic [1:0] base;
    } enc_res_t;

    // Leading zero bytes of a 64-bit word, 0..8
    function automatic logic [3:0] lz_bytes(input logic [63:0] v);
        logic [3:0] cnt;
        logic       found;
        cnt   = 4'd0;
        found = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (!found && v[63 - 8 * k -: 8] == 8'd0) begin
                cnt = cnt + 4'd1;
            end else begin
                found = 1'b1;
            end
        end
        return cnt;
    endfunction

endpackage

// ===== rtl/core/rlp_ram.sv =====
// Single-port-write, single-port-read byte store with registered read.
// Depends on rlp_pkg.
module rlp_ram import rlp_pkg::*; #(
    parameter int DEPTH = STORE_DEPTH,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/rlp_enc.sv =====
// Encoding sequencer: scans the signature, streams list items into the
// output store, then places the type prefix and list header. Uses rlp_pkg.
module rlp_enc import rlp_pkg::*; #(
    parameter int MAX_CALLDATA = MAX_CALLDATA_DEF,
    localparam int CDL_W = $clog2(MAX_CALLDATA + 2)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  int_fields_t         int_fields,
    input  logic [CDL_W-1:0]    cd_len,
    input  logic                include_sig,
    input  logic [9:0]          output_limit,
    output logic [8:0]          src_raddr,
    input  logic [7:0]          src_rdata,
    output logic                out_we,
    output logic [8:0]          out_waddr,
    output logic [7:0]          out_wdata,
    output enc_res_t            res
);

    localparam logic [6:0] SCAN_LAST = 7'd64;

    enc_state_t state_reg, state_next;

    logic [6:0] sc_reg, sc_d_reg;
    logic       pv_reg;
    logic       fr_reg, fs_reg;
    logic [5:0] lzr_reg, lzs_reg;
    logic [7:0] fbr_reg, fbs_reg;
    logic [7:0] cd0_reg;
    logic [3:0] item_reg;
    logic [8:0] j_reg;
    logic [8:0] fill_reg;
    logic [1:0] hcnt_reg;
    logic       cderr_reg;
    logic       wv_reg;
    logic       wsrc_reg;
    logic [8:0] wa_reg;
    logic [7:0] wconst_reg;

    logic       cd_err;
    logic [2:0] fi;
    logic [63:0] iv;
    logic [3:0] ilz, in_n;
    logic [1:0] hn;
    logic [8:0] dn;
    logic [7:0] h0, h1, h2;
    logic       is_src;
    logic [8:0] sbase;
    logic [8:0] k;
    logic [2:0] pos;
    logic [7:0] ibyte;
    logic [7:0] item_byte;
    logic       last_step;
    logic [5:0] slz, sn;
    logic [7:0] sfb;
    logic [8:0] cdl;
    logic [1:0] hl;
    logic [7:0] hb0, hb1;
    logic [7:0] hdr_byte;
    logic [9:0] total;

    assign cd_err = 9'(cd_len) > 9'(MAX_CALLDATA);
    assign cdl    = 9'(cd_len);

    // Current item: header bytes, data count and data source
    always_comb begin
        unique case (item_reg)
            ITEM_VALUE: fi = 3'd5;
            ITEM_V:     fi = 3'd6;
            default:    fi = item_reg[2:0];
        endcase
        iv    = int_fields[fi];
        ilz   = lz_bytes(iv);
        in_n  = 4'd8 - ilz;
        slz   = (item_reg == ITEM_R) ? lzr_reg : lzs_reg;
        sfb   = (item_reg == ITEM_R) ? fbr_reg : fbs_reg;
        sn    = 6'd32 - slz;
        hn    = 2'd1;
        dn    = 9'd0;
        h0    = STR_SHORT;
        h1    = 8'd0;
        h2    = 8'd0;
        is_src = 1'b0;
        sbase = 9'd0;
        priority if (item_reg == ITEM_ADDR) begin
            h0     = STR_SHORT + 8'(ADDR_LEN);
            dn     = 9'(ADDR_LEN);
            is_src = 1'b1;
        end else if (item_reg == ITEM_DATA) begin
            is_src = 1'b1;
            sbase  = SRC_CD_BASE;
            dn     = cdl;
            if (cdl == 9'd1 && !cd0_reg[7]) begin
                hn = 2'd0;
            end else if (cdl <= 9'(SHORT_MAX)) begin
                h0 = STR_SHORT + cdl[7:0];
            end else if (!cdl[8]) begin
                hn = 2'd2;
                h0 = STR_LONG + 8'd1;
                h1 = cdl[7:0];
            end else begin
                hn = 2'd3;
                h0 = STR_LONG + 8'd2;
                h1 = {7'd0, cdl[8]};
                h2 = cdl[7:0];
            end
        end else if (item_reg == ITEM_ACL) begin
            h0 = LIST_SHORT;
        end else if (item_reg == ITEM_R || item_reg == ITEM_S) begin
            is_src = 1'b1;
            sbase  = SRC_SIG_BASE + ((item_reg == ITEM_S) ? 9'd32 : 9'd0) + 9'(slz);
            if (sn == 6'd0) begin
                dn = 9'd0;
            end else if (sn == 6'd1 && !sfb[7]) begin
                hn = 2'd0;
                dn = 9'd1;
            end else begin
                h0 = STR_SHORT + 8'(sn);
                dn = 9'(sn);
            end
        end else begin
            if (in_n == 4'd0) begin
                dn = 9'd0;
            end else if (in_n == 4'd1 && !iv[7]) begin
                hn = 2'd0;
                dn = 9'd1;
            end else begin
                h0 = STR_SHORT + 8'(in_n);
                dn = 9'(in_n);
            end
        end
        k         = j_reg - 9'(hn);
        pos       = ilz[2:0] + k[2:0];
        ibyte     = 8'(iv >> {3'd7 - pos, 3'b000});
        last_step = (j_reg == 9'(hn) + dn - 9'd1);
        if (j_reg < 9'(hn)) begin
            unique case (j_reg[1:0])
                2'd0:    item_byte = h0;
                2'd1:    item_byte = h1;
                default: item_byte = h2;
            endcase
        end else begin
            item_byte = ibyte;
        end
    end

    // List header from the final byte count of the items
    always_comb begin
        if (fill_reg <= 9'(SHORT_MAX)) begin
            hl  = 2'd1;
            hb0 = LIST_SHORT + fill_reg[7:0];
        end else if (!fill_reg[8]) begin
            hl  = 2'd2;
            hb0 = LIST_LONG + 8'd1;
        end else begin
            hl  = 2'd3;
            hb0 = LIST_LONG + 8'd2;
        end
        hb1 = (hl == 2'd2) ? fill_reg[7:0] : {7'd0, fill_reg[8]};
        unique case (hcnt_reg)
            2'd0:    hdr_byte = TX_TYPE;
            2'd1:    hdr_byte = hb0;
            2'd2:    hdr_byte = hb1;
            default: hdr_byte = fill_reg[7:0];
        endcase
        total = 10'd1 + 10'(hl) + 10'(fill_reg);
    end

    always_comb begin
        state_next = state_reg;
        src_raddr  = 9'd0;
        unique case (state_reg)
            E_IDLE: begin
                if (start) begin
                    state_next = cd_err ? E_DONE : E_SCAN;
                end
            end
            E_SCAN: begin
                src_raddr = (sc_reg == SCAN_LAST) ? SRC_CD_BASE : SRC_SIG_BASE + 9'(sc_reg);
                if (pv_reg && sc_d_reg == SCAN_LAST) begin
                    state_next = E_ITEM;
                end
            end
            E_ITEM: begin
                src_raddr = sbase + k;
                if (last_step && (item_reg == ITEM_S || (item_reg == ITEM_ACL && !include_sig)))
                begin
                    state_next = E_HDR;
                end
            end
            E_HDR: begin
                if (hcnt_reg == hl) begin
                    state_next = E_DONE;
                end
            end
            E_DONE: state_next = E_IDLE;
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            wv_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            wv_reg    <= (state_reg == E_ITEM) || (state_reg == E_HDR);
            pv_reg    <= (state_reg == E_SCAN);
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            E_IDLE: begin
                cderr_reg <= cd_err;
                sc_reg    <= 7'd0;
                fr_reg    <= 1'b0;
                fs_reg    <= 1'b0;
                lzr_reg   <= 6'd32;
                lzs_reg   <= 6'd32;
                fbr_reg   <= 8'd0;
                fbs_reg   <= 8'd0;
            end
            E_SCAN: begin
                if (sc_reg != SCAN_LAST) begin
                    sc_reg <= sc_reg + 7'd1;
                end
                sc_d_reg <= sc_reg;
                if (pv_reg) begin
                    // first nonzero byte of r, then of s
                    if (sc_d_reg[6:5] == 2'b00 && !fr_reg && src_rdata != 8'd0) begin
                        fr_reg  <= 1'b1;
                        lzr_reg <= {1'b0, sc_d_reg[4:0]};
                        fbr_reg <= src_rdata;
                    end
                    if (sc_d_reg[6:5] == 2'b01 && !fs_reg && src_rdata != 8'd0) begin
                        fs_reg  <= 1'b1;
                        lzs_reg <= {1'b0, sc_d_reg[4:0]};
                        fbs_reg <= src_rdata;
                    end
                    if (sc_d_reg == SCAN_LAST) begin
                        cd0_reg  <= src_rdata;
                        item_reg <= 4'd0;
                        j_reg    <= 9'd0;
                        fill_reg <= 9'd0;
                    end
                end
            end
            E_ITEM: begin
                wa_reg     <= HDR_ROOM + fill_reg;
                fill_reg   <= fill_reg + 9'd1;
                wsrc_reg   <= is_src && (j_reg >= 9'(hn));
                wconst_reg <= item_byte;
                hcnt_reg   <= 2'd0;
                if (last_step) begin
                    j_reg    <= 9'd0;
                    item_reg <= item_reg + 4'd1;
                end else begin
                    j_reg <= j_reg + 9'd1;
                end
            end
            E_HDR: begin
                wa_reg     <= 9'(2'd3 - hl) + 9'(hcnt_reg);
                wsrc_reg   <= 1'b0;
                wconst_reg <= hdr_byte;
                hcnt_reg   <= hcnt_reg + 2'd1;
            end
            default: begin
            end
        endcase
    end

    assign out_we    = wv_reg;
    assign out_waddr = wa_reg;
    assign out_wdata = wsrc_reg ? src_rdata : wconst_reg;

    always_comb begin
        res.done = (state_reg == E_DONE);
        if (cderr_reg) begin
            res.status = ST_CALLDATA;
        end else if (total > output_limit) begin
            res.status = ST_LIMIT;
        end else begin
            res.status = ST_OK;
        end
        res.length = (res.status == ST_OK) ? total : 10'd0;
        res.base   = 2'd3 - hl;
    end

endmodule

// ===== rtl/core/rlp_typed_transaction_serializer_top.sv =====
// Top level of the typed (0x02) transaction serializer.
// Depends on rlp_pkg, rlp_ram, rlp_enc and the assertion macro header.
//
// Use: load integers (tuser 0) and bytes (tuser 1) on the s_ channel, then
// send begin (tuser 2). Begin returns one m_ transfer: a report with total
// length and status. Each read (tuser 3) returns one m_ transfer with the
// next encoded byte, tlast on the final byte and on every read past the end.
// Loads return nothing.
// A read makes one output store access with registered data.
// Begin raises m_tvalid once a pass has read the signature bytes and the
// first calldata byte, the sequencer has written one output byte per cycle
// into the output store, and the report has then been handed over; a
// too-long calldata skips the pass and answers at once.
// The input is held off while a begin or read is busy, and a begin or read
// is held off while an earlier result waits on m_tready; loads still pass.
// Reset clears control state, configuration and calldata length; the byte stores are left as is.
// Configuration goes over the APB port, to be written only while idle; the block does not enforce this.
`include "rlp_typed_transaction_serializer_top_defines.svh"

module rlp_typed_transaction_serializer_top import rlp_pkg::*; #(
    parameter int MAX_CALLDATA = MAX_CALLDATA_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] field_index, [66:3] value_word, [68:67] byte_target,
    // [76:69] byte_index, [84:77] byte_value, [87:85] zero
    input  logic [87:0] s_tdata,
    // [1:0] command
    input  logic [1:0]  s_tuser,
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte, [17:8] total_length, [19:18] status, [23:20] zero
    output logic [23:0] m_tdata,
    // [0] out_kind
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    localparam int CDL_W = $clog2(MAX_CALLDATA + 2);

    top_state_t state_reg, state_next;

    logic              sig_reg;
    logic [9:0]        limit_reg;
    int_fields_t       intf_reg;
    logic [CDL_W-1:0]  cdl_reg;
    logic [9:0]        len_reg;
    logic [1:0]        status_reg;
    logic [1:0]        base_reg;
    logic [9:0]        rpos_reg;
    logic              rd_hit_reg, rd_last_reg;

    logic              mv_reg;
    logic [7:0]        mbyte_reg;
    logic [9:0]        mtotal_reg;
    logic [1:0]        mstatus_reg;
    logic              mkind_reg, mlast_reg;

    logic [2:0]  field_index;
    logic [63:0] value_word;
    logic [1:0]  byte_target;
    logic [7:0]  byte_index, byte_value;
    logic [1:0]  command;
    logic        s_acc;
    logic        rd_hit;

    logic        src_we;
    logic [8:0]  src_waddr, src_raddr, out_waddr, out_raddr;
    logic [7:0]  src_rdata, out_wdata, out_rdata;
    logic        out_we;
    logic        start;
    enc_res_t    enc_res;

    assign field_index = s_tdata[2:0];
    assign value_word  = s_tdata[66:3];
    assign byte_target = s_tdata[68:67];
    assign byte_index  = s_tdata[76:69];
    assign byte_value  = s_tdata[84:77];
    assign command     = s_tuser;

    // Loads never produce a result, so they pass a stalled output
    assign s_tready = (state_reg == T_IDLE) &&
                      (!command[1] || !mv_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;
    assign start    = s_acc && command == CMD_BEGIN;

    // Configuration: pready tied high, writes land on the access cycle
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OUTPUT_LIMIT) ? {22'd0, limit_reg} : {31'd0, sig_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_reg   <= 1'b1;
            limit_reg <= 10'd1023;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_INCLUDE_SIG) begin
                sig_reg <= pwdata[0];
            end else begin
                limit_reg <= pwdata[9:0];
            end
        end
    end

    // Byte loads: map target and index onto the source store, drop out-of-range
    always_comb begin
        src_we    = 1'b0;
        src_waddr = 9'd0;
        if (s_acc && command == CMD_LOAD_BYTE) begin
            unique case (byte_target)
                TGT_ADDR: begin
                    src_we    = byte_index < 8'(ADDR_LEN);
                    src_waddr = 9'(byte_index);
                end
                TGT_DATA: begin
                    src_we    = 9'(byte_index) < 9'(MAX_CALLDATA);
                    src_waddr = SRC_CD_BASE + 9'(byte_index);
                end
                default: begin
                    src_we    = byte_index < 8'd32;
                    src_waddr = SRC_SIG_BASE + {3'd0, byte_target[0], byte_index[4:0]};
                end
            endcase
        end
    end

    // Integer loads; calldata length saturates one past MAX_CALLDATA
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cdl_reg <= '0;
        end else if (s_acc && command == CMD_LOAD_INT) begin
            if (field_index == FIELD_CD_LEN) begin
                cdl_reg <= (value_word > 64'(MAX_CALLDATA)) ?
                           CDL_W'(MAX_CALLDATA + 1) : value_word[CDL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && command == CMD_LOAD_INT && field_index != FIELD_CD_LEN) begin
            intf_reg[field_index] <= value_word;
        end
    end

    rlp_ram #(.DEPTH(STORE_DEPTH), .WIDTH(8)) u_src_ram (
        .aclk  (aclk),
        .we    (src_we),
        .waddr (src_waddr),
        .wdata (byte_value),
        .raddr (src_raddr),
        .rdata (src_rdata)
    );

    rlp_enc #(.MAX_CALLDATA(MAX_CALLDATA)) u_enc (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (start),
        .int_fields   (intf_reg),
        .cd_len       (cdl_reg),
        .include_sig  (sig_reg),
        .output_limit (limit_reg),
        .src_raddr    (src_raddr),
        .src_rdata    (src_rdata),
        .out_we       (out_we),
        .out_waddr    (out_waddr),
        .out_wdata    (out_wdata),
        .res          (enc_res)
    );

    // Encoded bytes start at the header offset left by the last begin
    assign out_raddr = 9'(base_reg) + rpos_reg[8:0];
    assign rd_hit    = rpos_reg < len_reg;

    rlp_ram #(.DEPTH(STORE_DEPTH), .WIDTH(8)) u_out_ram (
        .aclk  (aclk),
        .we    (out_we),
        .waddr (out_waddr),
        .wdata (out_wdata),
        .raddr (out_raddr),
        .rdata (out_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: begin
                if (s_acc && command == CMD_BEGIN) begin
                    state_next = T_ENC;
                end else if (s_acc && command == CMD_READ) begin
                    state_next = T_RD;
                end
            end
            T_ENC: begin
                if (enc_res.done) begin
                    state_next = T_IDLE;
                end
            end
            T_RD:    state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= T_IDLE;
            len_reg    <= 10'd0;
            status_reg <= ST_OK;
            base_reg   <= 2'd0;
            rpos_reg   <= 10'd0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mv_reg && m_tready) begin
                mv_reg <= 1'b0;
            end
            // Capture the read position check with the store access
            if (s_acc && command == CMD_READ) begin
                rd_hit_reg  <= rd_hit;
                rd_last_reg <= !rd_hit || (rpos_reg + 10'd1 == len_reg);
                if (rd_hit) begin
                    rpos_reg <= rpos_reg + 10'd1;
                end
            end
            if (state_reg == T_ENC && enc_res.done) begin
                len_reg     <= enc_res.length;
                status_reg  <= enc_res.status;
                base_reg    <= enc_res.base;
                rpos_reg    <= 10'd0;
                mv_reg      <= 1'b1;
                mkind_reg   <= KIND_REPORT;
                mbyte_reg   <= 8'd0;
                mtotal_reg  <= enc_res.length;
                mstatus_reg <= enc_res.status;
                mlast_reg   <= 1'b0;
            end
            if (state_reg == T_RD) begin
                mv_reg      <= 1'b1;
                mkind_reg   <= KIND_DATA;
                mbyte_reg   <= rd_hit_reg ? out_rdata : 8'd0;
                mtotal_reg  <= len_reg;
                mstatus_reg <= status_reg;
                mlast_reg   <= rd_last_reg;
            end
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {4'd0, mstatus_reg, mtotal_reg, mbyte_reg};
    assign m_tuser  = mkind_reg;
    assign m_tlast  = mlast_reg;

    `RLP_ASSERT_IMP(a_err_zero_len, m_tvalid && m_tuser[0] == KIND_REPORT && m_tdata[19:18] != ST_OK, m_tdata[17:8] == 10'd0, "failed begin reports nonzero length")
    `RLP_ASSERT_IMP(a_past_end_last, m_tvalid && m_tuser[0] == KIND_DATA && m_tdata[17:8] == 10'd0, m_tlast && m_tdata[7:0] == 8'd0, "read past end not flagged")
    `RLP_ASSERT_IMP(a_done_in_enc, enc_res.done, state_reg == T_ENC, "encoder finished outside a begin")
    `RLP_ASSERT_NXT(a_begin_busy, start, state_reg == T_ENC && !s_tready, "begin did not hold off input")

endmodule
